### hdl/fht_pkg.sv
// ----------------------------------------------------------------------------
// fht_pkg
// Shared types and constants of the fragment hole tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fht_pkg;

   // Entries in the request queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // One classified request as it travels from front to back
   typedef struct packed {
      logic        new_datagram;
      logic [15:0] total_length;
      logic [15:0] frag_offset;
      logic [16:0] frag_end;      // offset + length, no wrap
   } req_type;

endpackage

`default_nettype wire

### hdl/fragment_hole_tracker.sv
// ----------------------------------------------------------------------------
// fragment_hole_tracker
// Tracks the missing byte ranges of one datagram as an ordered hole table.
// ----------------------------------------------------------------------------
//
//   channel   ports                                        handshake
//   request   req_new_datagram, req_total_length,          start && !busy
//             req_frag_offset, req_frag_length
//   response  rsp_accepted, rsp_complete,                  rsp_strobe, 1 cycle
//             rsp_table_overflow
//
// While a request runs, the engine reads one hole per cycle from the table
// memory and moves one entry per cycle when a hole is removed or split.
// busy is high for one cycle after each request and stays high while the
// request queue is full. Synchronous reset empties the table and the queue.
// The receiver cannot stall; each response is shown for one cycle only.
//
`timescale 1ns / 1ps
`default_nettype none

module fragment_hole_tracker #(
   parameter int MAX_HOLES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_new_datagram,
   input  wire logic [15:0] req_total_length,
   input  wire logic [15:0] req_frag_offset,
   input  wire logic [15:0] req_frag_length,
   output logic             rsp_strobe,
   output logic             rsp_accepted,
   output logic             rsp_complete,
   output logic             rsp_table_overflow
);

   logic             q_full;
   logic             q_push;
   fht_pkg::req_type q_push_item;
   logic             q_pop;
   logic             q_valid;
   fht_pkg::req_type q_head;

   // Capture and classify requests
   fht_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_new_datagram (req_new_datagram),
      .req_total_length (req_total_length),
      .req_frag_offset  (req_frag_offset),
      .req_frag_length  (req_frag_length),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (q_push_item)
   );

   // Decouple front and engine
   fht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_head)
   );

   // Update the hole table
   fht_engine #(
      .MAX_HOLES (MAX_HOLES)
   ) u_engine (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_head),
      .q_pop              (q_pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_accepted       (rsp_accepted),
      .rsp_complete       (rsp_complete),
      .rsp_table_overflow (rsp_table_overflow)
   );

endmodule

`default_nettype wire

### hdl/fht_front.sv
// ----------------------------------------------------------------------------
// fht_front
// Request capture stage: takes a request, forms the fragment end offset and
// hands the classified request to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fht_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic             req_new_datagram,
   input  wire logic [15:0]      req_total_length,
   input  wire logic [15:0]      req_frag_offset,
   input  wire logic [15:0]      req_frag_length,
   input  wire logic             q_full,
   output logic                  q_push,
   output fht_pkg::req_type      q_item
);

   logic             valid_ff;
   logic             valid_in;
   fht_pkg::req_type item_ff;
   fht_pkg::req_type item_in;
   logic             take;

   assign busy   = valid_ff;
   assign take   = start && !valid_ff;
   assign q_push = valid_ff && !q_full;
   assign q_item = item_ff;

   // Capture a request and form its end offset at 17 bits
   always_comb begin
      item_in = item_ff;
      if (take) begin
         item_in.new_datagram = req_new_datagram;
         item_in.total_length = req_total_length;
         item_in.frag_offset  = req_frag_offset;
         item_in.frag_end     = {1'b0, req_frag_offset} + {1'b0, req_frag_length};
      end
   end

   // Hold the request until the queue has room
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

### hdl/fht_queue.sv
// ----------------------------------------------------------------------------
// fht_queue
// Short request queue that decouples the front stage from the hole engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fht_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire fht_pkg::req_type push_item,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output fht_pkg::req_type      head_item
);

   localparam int PW = (fht_pkg::QUEUE_DEPTH > 1) ? $clog2(fht_pkg::QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(fht_pkg::QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(fht_pkg::QUEUE_DEPTH - 1);

   fht_pkg::req_type slot_ff [fht_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [FW-1:0]    fill_ff;
   logic [FW-1:0]    fill_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (fill_ff == FW'(fht_pkg::QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### hdl/fht_engine.sv
// ----------------------------------------------------------------------------
// fht_engine
// Hole table engine: scans the ordered hole table one entry per cycle,
// then trims, removes or splits the matching hole, shifting entries one
// per cycle through a single-port-write, single-port-read memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fht_engine #(
   parameter int MAX_HOLES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire fht_pkg::req_type q_item,
   output logic                  q_pop,
   output logic                  rsp_strobe,
   output logic                  rsp_accepted,
   output logic                  rsp_complete,
   output logic                  rsp_table_overflow
);

   localparam int AW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
   localparam int CW = $clog2(MAX_HOLES + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_NEWD  = 3'd1;
   localparam logic [2:0] S_ISSUE = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_SHD   = 3'd4;
   localparam logic [2:0] S_SHU   = 3'd5;
   localparam logic [2:0] S_SPL1  = 3'd6;
   localparam logic [2:0] S_SPL2  = 3'd7;

   // Hole table: {start, end} per entry
   logic [31:0]      mem [MAX_HOLES];
   logic [31:0]      rd_data_ff;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [31:0]      wr_data;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   fht_pkg::req_type work_ff, work_in;
   logic [15:0]      hs_ff, hs_in;
   logic [15:0]      he_ff, he_in;
   logic             strobe_ff, strobe_in;
   logic             acc_ff, acc_in;
   logic             cmp_ff, cmp_in;
   logic             ovf_ff, ovf_in;

   logic [15:0]      hs;
   logic [15:0]      he;
   logic             fits;
   logic [CW-1:0]    idx_next;
   logic [CW:0]      idx_plus3;

   assign hs        = rd_data_ff[31:16];
   assign he        = rd_data_ff[15:0];
   assign fits      = (hs <= work_ff.frag_offset) && (work_ff.frag_end <= {1'b0, he});
   assign idx_next  = idx_ff + 1'b1;
   assign idx_plus3 = {1'b0, idx_ff} + (CW+1)'(3);

   assign rsp_strobe         = strobe_ff;
   assign rsp_accepted       = acc_ff;
   assign rsp_complete       = cmp_ff;
   assign rsp_table_overflow = ovf_ff;

   // Sequence scan, update and shifts
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      ptr_in    = ptr_ff;
      work_in   = work_ff;
      hs_in     = hs_ff;
      he_in     = he_ff;
      strobe_in = 1'b0;
      acc_in    = acc_ff;
      cmp_in    = cmp_ff;
      ovf_in    = ovf_ff;
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = rd_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               work_in = q_item;
               idx_in  = '0;
               if (q_item.new_datagram) begin
                  state_in = S_NEWD;
               end else if (count_ff == '0) begin
                  strobe_in = 1'b1;
                  acc_in    = 1'b0;
                  cmp_in    = 1'b1;
                  ovf_in    = 1'b0;
               end else begin
                  rd_en    = 1'b1;
                  state_in = S_CHECK;
               end
            end
         end
         S_NEWD: begin
            // Open a single hole over the whole datagram
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {16'h0000, work_ff.total_length};
            count_in = CW'(1);
            state_in = S_ISSUE;
         end
         S_ISSUE: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!fits) begin
               // Advance to the next hole, or reject at the end of the table
               if (idx_next < count_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_next[AW-1:0];
                  idx_in  = idx_next;
               end else begin
                  strobe_in = 1'b1;
                  acc_in    = 1'b0;
                  cmp_in    = (count_ff == '0);
                  ovf_in    = 1'b0;
                  state_in  = S_IDLE;
               end
            end else if (hs == work_ff.frag_offset) begin
               if (work_ff.frag_end == {1'b0, he}) begin
                  // Remove the hole, closing the gap if entries follow
                  if (idx_next == count_ff) begin
                     count_in  = count_ff - 1'b1;
                     strobe_in = 1'b1;
                     acc_in    = 1'b1;
                     cmp_in    = (count_in == '0);
                     ovf_in    = 1'b0;
                     state_in  = S_IDLE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = idx_next[AW-1:0];
                     ptr_in   = idx_ff;
                     state_in = S_SHD;
                  end
               end else begin
                  // Trim the hole at its front
                  wr_en     = 1'b1;
                  wr_addr   = idx_ff[AW-1:0];
                  wr_data   = {work_ff.frag_end[15:0], he};
                  strobe_in = 1'b1;
                  acc_in    = 1'b1;
                  cmp_in    = 1'b0;
                  ovf_in    = 1'b0;
                  state_in  = S_IDLE;
               end
            end else if (work_ff.frag_end == {1'b0, he}) begin
               // Trim the hole at its back
               wr_en     = 1'b1;
               wr_addr   = idx_ff[AW-1:0];
               wr_data   = {hs, work_ff.frag_offset};
               strobe_in = 1'b1;
               acc_in    = 1'b1;
               cmp_in    = 1'b0;
               ovf_in    = 1'b0;
               state_in  = S_IDLE;
            end else if (count_ff >= CW'(MAX_HOLES)) begin
               // Drop the fragment: no room for a split
               strobe_in = 1'b1;
               acc_in    = 1'b0;
               cmp_in    = 1'b0;
               ovf_in    = 1'b1;
               state_in  = S_IDLE;
            end else begin
               // Split: make room after the hole if entries follow
               hs_in = hs;
               he_in = he;
               if (idx_next == count_ff) begin
                  state_in = S_SPL1;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = AW'(count_ff - 1'b1);
                  ptr_in   = count_ff;
                  state_in = S_SHU;
               end
            end
         end
         S_SHD: begin
            // Move one entry down
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = rd_data_ff;
            if ((ptr_ff + CW'(2)) < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = AW'(ptr_ff + CW'(2));
               ptr_in  = ptr_ff + 1'b1;
            end else begin
               count_in  = count_ff - 1'b1;
               strobe_in = 1'b1;
               acc_in    = 1'b1;
               cmp_in    = (count_in == '0);
               ovf_in    = 1'b0;
               state_in  = S_IDLE;
            end
         end
         S_SHU: begin
            // Move one entry up
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            wr_data = rd_data_ff;
            if ({1'b0, ptr_ff} >= idx_plus3) begin
               rd_en   = 1'b1;
               rd_addr = AW'(ptr_ff - CW'(2));
               ptr_in  = ptr_ff - 1'b1;
            end else begin
               state_in = S_SPL1;
            end
         end
         S_SPL1: begin
            // Write the back piece
            wr_en    = 1'b1;
            wr_addr  = idx_next[AW-1:0];
            wr_data  = {work_ff.frag_end[15:0], he_ff};
            state_in = S_SPL2;
         end
         S_SPL2: begin
            // Write the front piece in place of the old hole
            wr_en     = 1'b1;
            wr_addr   = idx_ff[AW-1:0];
            wr_data   = {hs_ff, work_ff.frag_offset};
            count_in  = count_ff + 1'b1;
            strobe_in = 1'b1;
            acc_in    = 1'b1;
            cmp_in    = 1'b0;
            ovf_in    = 1'b0;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      ptr_ff  <= ptr_in;
      work_ff <= work_in;
      hs_ff   <= hs_in;
      he_ff   <= he_in;
      acc_ff  <= acc_in;
      cmp_ff  <= cmp_in;
      ovf_ff  <= ovf_in;
   end

   // Hole table memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### bench/tb_fragment_hole_tracker.sv
// ----------------------------------------------------------------------------
// tb_fragment_hole_tracker
// Self-checking bench for the fragment hole tracker.
// ----------------------------------------------------------------------------
// Requests come from a queue that the stimulus process fills. A clocked
// driver offers them on start/busy and may insert idle bursts. At each accepted
// request it runs a behavioral hole table and queues the verdict that the
// block should give. A monitor compares every rsp_strobe cycle with the oldest
// queued verdict. Stimulus is a short directed set (empty table, empty
// datagram, end past 64K, trims, zero-length fragments, table full on a split)
// followed by random datagrams cut into shuffled, partly corrupted pieces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fragment_hole_tracker;

   localparam int HOLE_SLOTS  = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 2 * HOLE_SLOTS + 16;
   localparam int RANDOM_BULK = 1500;
   localparam int RANDOM_ALL  = 1750;

   typedef struct packed {
      logic        new_datagram;
      logic [15:0] total_length;
      logic [15:0] frag_offset;
      logic [15:0] frag_length;
   } frag_req_type;

   typedef struct packed {
      logic accepted;
      logic complete;
      logic table_overflow;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_new_datagram = 1'b0;
   logic [15:0] req_total_length = '0;
   logic [15:0] req_frag_offset  = '0;
   logic [15:0] req_frag_length  = '0;
   logic        rsp_strobe;
   logic        rsp_accepted;
   logic        rsp_complete;
   logic        rsp_table_overflow;

   frag_req_type pending_frags[$];
   verdict_type  awaited_verdicts[$];
   frag_req_type cur_req = '0;
   int           gap_left = 0;
   bit           allow_gaps = 1'b1;
   int           errors = 0;
   int           gen_count = 0;
   int           quiet_cycles = 0;

   // behavioral hole table
   logic [15:0] hole_lo [HOLE_SLOTS];
   logic [15:0] hole_hi [HOLE_SLOTS];
   int          hole_cnt = 0;

   fragment_hole_tracker #(
      .MAX_HOLES(HOLE_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_new_datagram(req_new_datagram),
      .req_total_length(req_total_length),
      .req_frag_offset(req_frag_offset),
      .req_frag_length(req_frag_length),
      .rsp_strobe(rsp_strobe),
      .rsp_accepted(rsp_accepted),
      .rsp_complete(rsp_complete),
      .rsp_table_overflow(rsp_table_overflow)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one request to the hole table and return the verdict it yields
   function automatic verdict_type predict_fragment(frag_req_type r);
      verdict_type v;
      logic [16:0] f_end;
      logic [15:0] lo;
      logic [15:0] hi;
      bit          done;
      v = '0;
      done = 1'b0;
      f_end = {1'b0, r.frag_offset} + {1'b0, r.frag_length};
      if (r.new_datagram) begin
         hole_lo[0] = '0;
         hole_hi[0] = r.total_length;
         hole_cnt = 1;
      end
      // first hole that holds the whole fragment decides
      for (int i = 0; i < hole_cnt && !done; i++) begin
         lo = hole_lo[i];
         hi = hole_hi[i];
         if (lo <= r.frag_offset && f_end <= {1'b0, hi}) begin
            done = 1'b1;
            if (lo == r.frag_offset && f_end == {1'b0, hi}) begin
               for (int j = i; j < hole_cnt - 1; j++) begin
                  hole_lo[j] = hole_lo[j + 1];
                  hole_hi[j] = hole_hi[j + 1];
               end
               hole_cnt--;
               v.accepted = 1'b1;
            end else if (lo == r.frag_offset) begin
               hole_lo[i] = f_end[15:0];
               v.accepted = 1'b1;
            end else if (f_end == {1'b0, hi}) begin
               hole_hi[i] = r.frag_offset;
               v.accepted = 1'b1;
            end else if (hole_cnt >= HOLE_SLOTS) begin
               v.table_overflow = 1'b1;
            end else begin
               // open a slot; entry i keeps its start and becomes the front piece
               for (int j = hole_cnt; j > i; j--) begin
                  hole_lo[j] = hole_lo[j - 1];
                  hole_hi[j] = hole_hi[j - 1];
               end
               hole_hi[i] = r.frag_offset;
               hole_lo[i + 1] = f_end[15:0];
               hole_hi[i + 1] = hi;
               hole_cnt++;
               v.accepted = 1'b1;
            end
         end
      end
      v.complete = (hole_cnt == 0);
      return v;
   endfunction

   task automatic push_req(logic nd, int unsigned tot, int unsigned off, int unsigned len);
      frag_req_type r;
      r.new_datagram = nd;
      r.total_length = tot[15:0];
      r.frag_offset  = off[15:0];
      r.frag_length  = len[15:0];
      pending_frags.insert(pending_frags.size(), r);
      gen_count++;
   endtask

   // Cut one datagram into pieces, possibly reorder them and corrupt a few
   task automatic push_datagram();
      int unsigned offs[$];
      int unsigned lens[$];
      int unsigned total;
      int unsigned pos;
      int unsigned span;
      int unsigned cut_max;
      int unsigned tmp;
      int unsigned off;
      int unsigned len;
      int          sel;
      int          mode;
      int          j;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         total = 0;
      end else if (sel <= 2) begin
         total = $urandom_range(0, 65535);
      end else begin
         total = $urandom_range(1, 3000);
      end
      cut_max = total * 2 / $urandom_range(1, 24) + 1;
      pos = 0;
      if (total == 0) begin
         offs.insert(offs.size(), 0);
         lens.insert(lens.size(), 0);
      end
      while (pos < total) begin
         if ($urandom_range(0, 15) == 0) begin
            offs.insert(offs.size(), pos);
            lens.insert(lens.size(), 0);
         end
         span = $urandom_range(1, cut_max);
         if (pos + span > total) begin
            span = total - pos;
         end
         offs.insert(offs.size(), pos);
         lens.insert(lens.size(), span);
         pos += span;
      end
      // in order, reversed, or shuffled
      mode = $urandom_range(0, 3);
      if (mode == 1) begin
         offs.reverse();
         lens.reverse();
      end else if (mode >= 2) begin
         for (int i = offs.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = offs[i]; offs[i] = offs[j]; offs[j] = tmp;
            tmp = lens[i]; lens[i] = lens[j]; lens[j] = tmp;
         end
      end
      foreach (offs[i]) begin
         off = offs[i];
         len = lens[i];
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            off += $urandom_range(1, 8);
         end else if (sel == 1) begin
            len += $urandom_range(1, 8);
         end else if (sel == 2) begin
            push_req(1'b0, $urandom_range(0, 65535), off, len);
         end
         if (i == 0) begin
            push_req(1'b1, total, off, len);
         end else begin
            push_req(1'b0, $urandom_range(0, 65535), off, len);
         end
      end
   endtask

   // Wait until the block has nothing left to do
   task automatic wait_drained();
      while (pending_frags.size() != 0 || start || awaited_verdicts.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic report_field(string name, logic want, logic got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
         errors++;
      end
   endtask

   // Driver: offer requests, predict at acceptance, insert idle bursts
   always @(posedge clock) begin
      logic fire;
      logic go;
      if (!reset) begin
         fire = start && !busy;
         if (fire) begin
            awaited_verdicts.insert(awaited_verdicts.size(), predict_fragment(cur_req));
         end
         if (fire || !start) begin
            go = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (fire && allow_gaps && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 13);
            end else if (pending_frags.size() > 0) begin
               cur_req = pending_frags.pop_front();
               go = 1'b1;
            end
            start <= go;
            req_new_datagram <= cur_req.new_datagram;
            req_total_length <= cur_req.total_length;
            req_frag_offset  <= cur_req.frag_offset;
            req_frag_length  <= cur_req.frag_length;
         end
      end
   end

   // Monitor: compare each response with the oldest outstanding verdict
   always @(negedge clock) begin
      verdict_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (awaited_verdicts.size() == 0) begin
               $display("%0t: response with no request outstanding, expected none, actual %b%b%b",
                        $time, rsp_accepted, rsp_complete, rsp_table_overflow);
               errors++;
            end else begin
               want = awaited_verdicts.pop_front();
               report_field("accepted", want.accepted, rsp_accepted);
               report_field("complete", want.complete, rsp_complete);
               report_field("table_overflow", want.table_overflow, rsp_table_overflow);
            end
         end else if (rsp_strobe !== 1'b0) begin
            $display("%0t: rsp_strobe unknown, expected 0 or 1, actual %b", $time, rsp_strobe);
            errors++;
         end
      end
   end

   // Watchdog: end the run when no request is accepted and no response comes for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no request or response accepted for %0d cycles", $time, QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // a fragment with no datagram open, then an empty datagram
      push_req(1'b0, 16'h1234, 0, 0);
      push_req(1'b1, 0, 0, 0);
      // end past 64K never fits, full-length fragment completes
      push_req(1'b1, 65535, 65535, 1);
      push_req(1'b0, 0, 65535, 65535);
      push_req(1'b0, 0, 0, 65535);
      // split, back trim, zero-length trim and split, crossing fragment
      push_req(1'b1, 1000, 100, 100);
      push_req(1'b0, 0, 50, 50);
      push_req(1'b0, 0, 0, 0);
      push_req(1'b0, 0, 500, 0);
      push_req(1'b0, 0, 40, 20);
      // fill the table by splits, then a split with the table full
      push_req(1'b1, 1000, 20, 10);
      for (int k = 1; k < HOLE_SLOTS - 1; k++) begin
         push_req(1'b0, 0, 60 * k + 20, 10);
      end
      push_req(1'b0, 0, 950, 10);
      push_req(1'b0, 0, 990, 10);
      // hold off until every directed response has come back
      wait_drained();

      gen_count = 0;
      while (gen_count < RANDOM_BULK) begin
         if ($urandom_range(0, 9) == 0) begin
            push_req($urandom_range(0, 7) == 0, $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
         end else begin
            push_datagram();
         end
      end
      wait_drained();

      // back-to-back requests to finish
      allow_gaps = 1'b0;
      while (gen_count < RANDOM_ALL) begin
         push_datagram();
      end
      wait_drained();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (awaited_verdicts.size() != 0) begin
         $display("%0t: responses missing, expected %0d more, actual 0",
                  $time, awaited_verdicts.size());
         errors++;
      end
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
